// ===== rtl/core/bwb_pkg.sv =====
// Shared constants and codes for the benefit write buffer manager.
package bwb_pkg;

  localparam int BLOCK_W   = 20;
  localparam int SECTOR_W  = 20;
  localparam int BENEFIT_W = 32;
  localparam int AGE_W     = 32;
  localparam int ACTION_W  = 3;
  localparam int SLOT_OUT_W = 6;
  localparam int CFG_W     = 7;

  // 10000.0 in Q16.16: only benefits below this are eviction candidates
  localparam logic [BENEFIT_W-1:0] BENEFIT_CEIL = 32'd655360000;
  localparam logic [AGE_W-1:0]     AGE_MAX      = 32'hFFFF_FFFF;
  localparam logic [CFG_W-1:0]     ACTIVE_RESET = 7'd40;

  // result codes
  localparam logic [ACTION_W-1:0] ACT_UNTRACKED = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_HIT       = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_ADDED     = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_FULL      = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_ALLOC     = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_EVICT     = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_IGNORE    = 3'd6;

endpackage

// ===== rtl/core/bwb_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
module bwb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/benefit_write_buffer_manager.sv =====
// Top level: request sequencer over the slot table and sector store memories.
//
//  channel  | handshake              | word
//  ---------+------------------------+-----------------------------------------------
//  in       | in_valid / in_ready    | sector_known, sector_id, block_number, benefit
//  out      | out_valid / out_ready  | action, slot, evicted_block, evicted_duration
//  cfg      | cfg_valid / cfg_ready  | active_blocks
//
// A known request scans every occupied slot through the slot table, one per cycle
// (aging, tag match and minimum search); a block hit then walks the stored sectors.
// An untracked request skips the scan and goes straight to the result. rst clears
// the control state and the slot count; memory contents are left as they are. A
// new word is taken while the previous result still waits on out_ready.
module benefit_write_buffer_manager #(
  parameter int MAX_BLOCKS        = 64,
  parameter int SECTORS_PER_BLOCK = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        sector_known,
  input  logic [19:0] sector_id,
  input  logic [19:0] block_number,
  input  logic [31:0] benefit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  action,
  output logic [5:0]  slot,
  output logic [19:0] evicted_block,
  output logic [31:0] evicted_duration,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  active_blocks
);

  localparam int SW = $clog2(MAX_BLOCKS);
  localparam int UW = $clog2(MAX_BLOCKS + 1);
  localparam int KW = $clog2(SECTORS_PER_BLOCK);
  localparam int FW = $clog2(SECTORS_PER_BLOCK + 1);
  localparam int AW = (UW > bwb_pkg::CFG_W) ? UW : bwb_pkg::CFG_W;
  localparam int EW = bwb_pkg::BLOCK_W + bwb_pkg::BENEFIT_W + bwb_pkg::AGE_W + FW;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_DUP    = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  // slot table entry: block, benefit, age, fill
  typedef struct packed {
    logic [bwb_pkg::BLOCK_W-1:0]   blk;
    logic [bwb_pkg::BENEFIT_W-1:0] ben;
    logic [bwb_pkg::AGE_W-1:0]     age;
    logic [FW-1:0]                 fill;
  } entry_t;

  logic [2:0]  state;
  logic [6:0]  active_reg;
  logic [UW-1:0] used_slots;

  logic [bwb_pkg::SECTOR_W-1:0]  req_sec;
  logic [bwb_pkg::BLOCK_W-1:0]   req_blk;
  logic [bwb_pkg::BENEFIT_W-1:0] req_ben;

  logic [SW-1:0] scan_idx;
  logic          hit_found;
  logic [SW-1:0] hit_idx;
  entry_t        hit_entry;
  logic          min_found;
  logic [SW-1:0] min_idx;
  entry_t        min_entry;
  logic [KW-1:0] dup_k;
  logic          dup_seen;

  logic [bwb_pkg::ACTION_W-1:0] res_action;
  logic [SW-1:0]                res_slot;
  logic [bwb_pkg::BLOCK_W-1:0]  res_blk;
  logic [bwb_pkg::AGE_W-1:0]    res_dur;

  // memory ports
  logic          st_wr_en;
  logic [SW-1:0] st_wr_addr;
  entry_t        st_wr_data;
  logic [SW-1:0] st_rd_addr;
  logic [EW-1:0] st_rd_raw;
  entry_t        st_rd;
  logic                  ss_wr_en;
  logic [SW+KW-1:0]      ss_wr_addr;
  logic [bwb_pkg::SECTOR_W-1:0] ss_wr_data;
  logic [SW+KW-1:0]      ss_rd_addr;
  logic [bwb_pkg::SECTOR_W-1:0] ss_rd_data;

  logic          in_fire;
  logic          scan_last;
  logic [bwb_pkg::AGE_W-1:0] aged;
  entry_t        aged_entry;
  logic          tag_hit;
  logic          min_hit;
  logic [bwb_pkg::BENEFIT_W-1:0] min_cur;
  logic          can_alloc;
  logic          dup_now;
  logic          dup_last;
  logic          out_free;

  bwb_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_slot_table (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_raw)
  );

  bwb_ram #(.WIDTH(bwb_pkg::SECTOR_W), .DEPTH(MAX_BLOCKS * (2 ** KW))) u_sector_store (
    .clk     (clk),
    .wr_en   (ss_wr_en),
    .wr_addr (ss_wr_addr),
    .wr_data (ss_wr_data),
    .rd_addr (ss_rd_addr),
    .rd_data (ss_rd_data)
  );

  assign st_rd     = entry_t'(st_rd_raw);
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  // scan datapath: aging, tag match, minimum candidate
  assign scan_last  = (UW'(scan_idx) + UW'(1)) >= used_slots;
  assign aged       = (st_rd.age == bwb_pkg::AGE_MAX) ? st_rd.age : st_rd.age + 1'b1;
  always_comb begin
    aged_entry     = st_rd;
    aged_entry.age = aged;
  end
  assign tag_hit = (st_rd.blk == req_blk);
  assign min_cur = min_found ? min_entry.ben : bwb_pkg::BENEFIT_CEIL;
  assign min_hit = (st_rd.ben != '0) && (st_rd.ben < min_cur);

  assign can_alloc = (AW'(used_slots) < AW'(active_reg)) && (used_slots < UW'(MAX_BLOCKS));

  // duplicate walk over stored sectors
  assign dup_now  = dup_seen || (ss_rd_data == req_sec);
  assign dup_last = (FW'(dup_k) + FW'(1)) >= hit_entry.fill;

  // read addresses
  always_comb begin
    st_rd_addr = '0;
    if (state == ST_SCAN) begin
      st_rd_addr = scan_idx + 1'b1;
    end
    ss_rd_addr = {hit_idx, KW'(0)};
    if (state == ST_DUP) begin
      ss_rd_addr = {hit_idx, dup_k + 1'b1};
    end
  end

  // write ports
  always_comb begin
    st_wr_en   = 1'b0;
    st_wr_addr = scan_idx;
    st_wr_data = aged_entry;
    ss_wr_en   = 1'b0;
    ss_wr_addr = {used_slots[SW-1:0], KW'(0)};
    ss_wr_data = req_sec;
    case (state)
      ST_SCAN: begin
        st_wr_en = 1'b1;
      end
      ST_DECIDE: begin
        st_wr_data.blk  = req_blk;
        st_wr_data.ben  = req_ben;
        st_wr_data.age  = '0;
        st_wr_data.fill = FW'(1);
        if (!hit_found && can_alloc) begin
          st_wr_en   = 1'b1;
          st_wr_addr = used_slots[SW-1:0];
          ss_wr_en   = 1'b1;
        end else if (!hit_found && min_found && (req_ben > min_entry.ben)) begin
          st_wr_en   = 1'b1;
          st_wr_addr = min_idx;
          ss_wr_en   = 1'b1;
          ss_wr_addr = {min_idx, KW'(0)};
        end
      end
      ST_DUP: begin
        st_wr_addr      = hit_idx;
        st_wr_data      = hit_entry;
        st_wr_data.fill = hit_entry.fill + 1'b1;
        ss_wr_addr      = {hit_idx, hit_entry.fill[KW-1:0]};
        if (dup_last && !dup_now && (hit_entry.fill < FW'(SECTORS_PER_BLOCK))) begin
          st_wr_en = 1'b1;
          ss_wr_en = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_reg <= bwb_pkg::ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_reg <= active_blocks;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      used_slots <= '0;
      hit_found  <= 1'b0;
      min_found  <= 1'b0;
      dup_seen   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            req_sec   <= sector_id;
            req_blk   <= block_number;
            req_ben   <= benefit;
            scan_idx  <= '0;
            hit_found <= 1'b0;
            min_found <= 1'b0;
            dup_seen  <= 1'b0;
            dup_k     <= '0;
            res_slot  <= '0;
            res_blk   <= '0;
            res_dur   <= '0;
            if (!sector_known) begin
              res_action <= bwb_pkg::ACT_UNTRACKED;
              state      <= ST_DONE;
            end else if (used_slots == '0) begin
              state <= ST_DECIDE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (!hit_found && tag_hit) begin
            hit_found <= 1'b1;
            hit_idx   <= scan_idx;
            hit_entry <= aged_entry;
          end
          if (min_hit) begin
            min_found <= 1'b1;
            min_idx   <= scan_idx;
            min_entry <= aged_entry;
          end
          scan_idx <= scan_idx + 1'b1;
          if (scan_last) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (hit_found) begin
            state <= ST_DUP;
          end else if (can_alloc) begin
            res_action <= bwb_pkg::ACT_ALLOC;
            res_slot   <= used_slots[SW-1:0];
            used_slots <= used_slots + 1'b1;
            state      <= ST_DONE;
          end else if (min_found && (req_ben > min_entry.ben)) begin
            res_action <= bwb_pkg::ACT_EVICT;
            res_slot   <= min_idx;
            res_blk    <= min_entry.blk;
            res_dur    <= min_entry.age;
            state      <= ST_DONE;
          end else begin
            res_action <= bwb_pkg::ACT_IGNORE;
            state      <= ST_DONE;
          end
        end
        ST_DUP: begin
          dup_seen <= dup_now;
          dup_k    <= dup_k + 1'b1;
          if (dup_last) begin
            res_slot <= hit_idx;
            if (dup_now) begin
              res_action <= bwb_pkg::ACT_HIT;
            end else if (hit_entry.fill >= FW'(SECTORS_PER_BLOCK)) begin
              res_action <= bwb_pkg::ACT_FULL;
            end else begin
              res_action <= bwb_pkg::ACT_ADDED;
            end
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      action           <= res_action;
      slot             <= bwb_pkg::SLOT_OUT_W'(res_slot);
      evicted_block    <= res_blk;
      evicted_duration <= res_dur;
    end
  end

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_slots <= UW'(MAX_BLOCKS))
    else $error("slot count above table size");

  a_dup_needs_hit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUP) |-> hit_found)
    else $error("sector walk without block hit");

  a_evict_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && action != bwb_pkg::ACT_EVICT) |->
      (evicted_block == '0 && evicted_duration == '0))
    else $error("eviction fields set on non-eviction result");

  a_alloc_grows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE && !hit_found && can_alloc) |=>
      (used_slots == $past(used_slots) + 1'b1))
    else $error("allocation did not advance slot count");
`endif

endmodule
